>>> src/pee_pkg.sv
// shared constants and types for the prefix expression evaluator
`timescale 1ns / 1ps
package pee_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 32;
	localparam int unsigned WORD_W = 32;

	// character codes
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_MUL   = 8'h2A;
	localparam logic [7:0] CH_DIV   = 8'h2F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [WORD_W-1:0] EMPTY_POP = '1;

	// request to the shared multiply / divide unit
	typedef struct packed {
		logic start;
		logic is_div;
	} alu_req_t;

	// status back from the shared unit
	typedef struct packed {
		logic done;
		logic div_zero;
	} alu_rsp_t;

endpackage

>>> src/pee_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module pee_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/pee_alu.sv
// iterative 32-bit multiply and truncating divide around one shared adder
`timescale 1ns / 1ps
module pee_alu (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pee_pkg::alu_req_t                 req,
	input  logic [pee_pkg::WORD_W-1:0]        opa,
	input  logic [pee_pkg::WORD_W-1:0]        opb,
	output pee_pkg::alu_rsp_t                 rsp,
	output logic [pee_pkg::WORD_W-1:0]        result
);

	localparam int unsigned W = pee_pkg::WORD_W;
	localparam int unsigned SW = $clog2(W);

	localparam logic [1:0] A_IDLE = 2'd0;
	localparam logic [1:0] A_RUN  = 2'd1;
	localparam logic [1:0] A_FIX  = 2'd2;

	logic [1:0]    state_q;
	logic          is_div_q;
	logic          neg_q;
	logic [SW-1:0] step_q;
	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  res_q;
	logic          done_q;
	logic          dz_q;

	logic [W-1:0]  add_x;
	logic [W-1:0]  add_y;
	logic [W:0]    add_sum;
	logic [W-1:0]  mag_a;
	logic [W-1:0]  mag_b;

	// magnitudes of the operands for the divide
	assign mag_a = opa[W-1] ? (~opa + 1'b1) : opa;
	assign mag_b = opb[W-1] ? (~opb + 1'b1) : opb;

	// shared adder: accumulate for multiply, trial subtract for divide, negate at the end
	always_comb begin
		if (state_q == A_FIX) begin
			add_x = '0;
			add_y = b_q;
		end else if (is_div_q) begin
			add_x = {acc_q[W-2:0], b_q[W-1]};
			add_y = a_q;
		end else begin
			add_x = acc_q;
			add_y = a_q;
		end
		add_sum = {1'b0, add_x} + {1'b0, (is_div_q ? ~add_y : add_y)}
			+ {{W{1'b0}}, is_div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= A_IDLE;
			is_div_q <= 1'b0;
			done_q   <= 1'b0;
			dz_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				A_IDLE: begin
					if (req.start) begin
						is_div_q <= req.is_div;
						acc_q    <= '0;
						step_q   <= '0;
						dz_q     <= 1'b0;
						if (req.is_div) begin
							if (opb == '0) begin
								res_q  <= '0;
								dz_q   <= 1'b1;
								done_q <= 1'b1;
							end else begin
								a_q     <= mag_b;
								b_q     <= mag_a;
								neg_q   <= opa[W-1] ^ opb[W-1];
								state_q <= A_RUN;
							end
						end else begin
							a_q     <= opa;
							b_q     <= opb;
							state_q <= A_RUN;
						end
					end
				end
				A_RUN: begin
					if (is_div_q) begin
						acc_q <= add_sum[W] ? add_sum[W-1:0] : add_x;
						b_q   <= {b_q[W-2:0], add_sum[W]};
					end else begin
						if (b_q[0]) begin
							acc_q <= add_sum[W-1:0];
						end
						a_q <= {a_q[W-2:0], 1'b0};
						b_q <= {1'b0, b_q[W-1:1]};
					end
					step_q <= step_q + 1'b1;
					if (step_q == SW'(W - 1)) begin
						state_q <= A_FIX;
					end
				end
				A_FIX: begin
					if (is_div_q) begin
						res_q <= neg_q ? add_sum[W-1:0] : b_q;
					end else begin
						res_q <= acc_q;
					end
					done_q  <= 1'b1;
					state_q <= A_IDLE;
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	assign rsp.done     = done_q;
	assign rsp.div_zero = dz_q;
	assign result       = res_q;

endmodule

>>> src/prefix_expression_evaluator_top.sv
// top level of the prefix expression evaluator: sequencer, operand stack and result register
//
// usage:
// - input channel (in_valid / in_ready, char_code, last_char) takes one character word at a
//   time, fed from the end of the expression string toward its start; last_char marks the
//   first character of the string and closes the expression
// - digits push 0-9, spaces are skipped, + - * / pop top then next and push top op next,
//   any other code pops two and pushes zero
// - output channel (out_valid / out_ready, value and three sticky flags) carries one word per
//   expression, produced after the word with last_char is worked off
// - one word at a time: in_ready is high only while the sequencer is idle
// - * and / wait on the 32 steps of the shared multiply / divide unit; each stack pop goes
//   through the registered read port of the stack ram (an empty stack skips the read)
// - a word with last_char adds a final pop and the hand-off of the result
// - a result waiting on a stalled receiver sits in the output register; the block keeps
//   taking words and only holds at the end of the next expression until that register frees
// - reset empties the stack and clears the working flags and out_valid; stack contents need no clearing
`timescale 1ns / 1ps
module prefix_expression_evaluator_top #(
	parameter int unsigned STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        last_char,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] value,
	output logic        overflow_flag,
	output logic        underflow_flag,
	output logic        div_zero_flag
);

	localparam int unsigned W  = pee_pkg::WORD_W;
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);   // count holds 0..depth
	localparam int unsigned AW = $clog2(STACK_DEPTH);       // ram address

	// sequencer states
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DECODE   = 3'd1;
	localparam logic [2:0] S_POP      = 3'd2;
	localparam logic [2:0] S_POP_DATA = 3'd3;
	localparam logic [2:0] S_EXEC     = 3'd4;
	localparam logic [2:0] S_CALC     = 3'd5;
	localparam logic [2:0] S_PUSH     = 3'd6;
	localparam logic [2:0] S_EMIT     = 3'd7;

	// which operand a pop fills
	localparam logic [1:0] SEL_T     = 2'd0;
	localparam logic [1:0] SEL_U     = 2'd1;
	localparam logic [1:0] SEL_FINAL = 2'd2;

	logic [2:0]    state_q;
	logic [1:0]    sel_q;
	logic [7:0]    char_q;
	logic          last_q;
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic          unf_q;
	logic          dz_q;
	logic [W-1:0]  t_q;
	logic [W-1:0]  u_q;
	logic [W-1:0]  r_q;

	// output register
	logic          out_valid_q;
	logic [W-1:0]  value_q;
	logic          ovf_out_q;
	logic          unf_out_q;
	logic          dz_out_q;

	logic          stack_empty;
	logic          stack_full;
	logic [CW-1:0] count_dec;
	logic          ram_we;
	logic          ram_re;
	logic [W-1:0]  ram_rdata;
	logic          pop_store;
	logic [W-1:0]  pop_word;
	logic          emit_go;
	logic          is_digit;

	pee_pkg::alu_req_t alu_req;
	pee_pkg::alu_rsp_t alu_rsp;
	logic [W-1:0]      alu_result;

	assign stack_empty = (count_q == '0);
	assign stack_full  = (count_q == CW'(STACK_DEPTH));
	assign count_dec   = count_q - 1'b1;
	assign is_digit    = (char_q >= pee_pkg::CH_ZERO) && (char_q <= pee_pkg::CH_NINE);

	// stack ram: pushes write at count, pops read at count - 1
	assign ram_we = (state_q == S_PUSH) && !stack_full;
	assign ram_re = (state_q == S_POP) && !stack_empty;

	pee_ram #(
		.WIDTH(W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (r_q),
		.re    (ram_re),
		.raddr (count_dec[AW-1:0]),
		.rdata (ram_rdata)
	);

	// shared multiply / divide: top word is the left operand
	assign alu_req.start  = (state_q == S_EXEC)
		&& ((char_q == pee_pkg::CH_MUL) || (char_q == pee_pkg::CH_DIV));
	assign alu_req.is_div = (char_q == pee_pkg::CH_DIV);

	pee_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.opa    (t_q),
		.opb    (u_q),
		.rsp    (alu_rsp),
		.result (alu_result)
	);

	// a pop lands either straight away (empty stack gives all ones) or in the cycle after the read
	assign pop_store = ((state_q == S_POP) && stack_empty) || (state_q == S_POP_DATA);
	assign pop_word  = (state_q == S_POP) ? pee_pkg::EMPTY_POP : ram_rdata;

	assign emit_go  = (state_q == S_EMIT) && (!out_valid_q || out_ready);
	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= SEL_T;
			count_q <= '0;
			ovf_q   <= 1'b0;
			unf_q   <= 1'b0;
			dz_q    <= 1'b0;
		end else begin
			if (pop_store) begin
				unique case (sel_q)
					SEL_T: begin
						t_q     <= pop_word;
						sel_q   <= SEL_U;
						state_q <= S_POP;
					end
					SEL_U: begin
						u_q     <= pop_word;
						state_q <= S_EXEC;
					end
					default: begin
						r_q     <= pop_word;
						state_q <= S_EMIT;
					end
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						char_q  <= char_code;
						last_q  <= last_char;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (is_digit) begin
						r_q     <= {{(W - 8){1'b0}}, char_q - pee_pkg::CH_ZERO};
						state_q <= S_PUSH;
					end else if (char_q == pee_pkg::CH_SPACE) begin
						sel_q   <= SEL_FINAL;
						state_q <= last_q ? S_POP : S_IDLE;
					end else begin
						sel_q   <= SEL_T;
						state_q <= S_POP;
					end
				end
				S_POP: begin
					if (stack_empty) begin
						unf_q <= 1'b1;
					end else begin
						count_q <= count_dec;
						state_q <= S_POP_DATA;
					end
				end
				S_POP_DATA: begin
					// next state set by the pop store above
				end
				S_EXEC: begin
					case (char_q) inside
						pee_pkg::CH_PLUS: begin
							r_q     <= t_q + u_q;
							state_q <= S_PUSH;
						end
						pee_pkg::CH_MINUS: begin
							r_q     <= t_q - u_q;
							state_q <= S_PUSH;
						end
						pee_pkg::CH_MUL, pee_pkg::CH_DIV: begin
							state_q <= S_CALC;
						end
						default: begin
							r_q     <= '0;
							state_q <= S_PUSH;
						end
					endcase
				end
				S_CALC: begin
					if (alu_rsp.done) begin
						r_q     <= alu_result;
						dz_q    <= dz_q | alu_rsp.div_zero;
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (stack_full) begin
						ovf_q <= 1'b1;
					end else begin
						count_q <= count_q + 1'b1;
					end
					sel_q   <= SEL_FINAL;
					state_q <= last_q ? S_POP : S_IDLE;
				end
				S_EMIT: begin
					if (emit_go) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						unf_q   <= 1'b0;
						dz_q    <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			value_q   <= r_q;
			ovf_out_q <= ovf_q;
			unf_out_q <= unf_q;
			dz_out_q  <= dz_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign value          = value_q;
	assign overflow_flag  = ovf_out_q;
	assign underflow_flag = unf_out_q;
	assign div_zero_flag  = dz_out_q;

	// the stack never holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	// a full stack is never written
	a_no_full_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !stack_full)
		else $error("push written into a full stack");

	// the shared unit only reports back while the sequencer waits for it
	a_alu_done_calc: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> (state_q == S_CALC))
		else $error("multiply/divide finished outside its wait state");

	// handing off a result leaves a clean stack and flags for the next expression
	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> (count_q == '0) && !ovf_q && !unf_q && !dz_q && out_valid_q)
		else $error("expression state not cleared after result");

endmodule
